[hdl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types, codes and control word layout of the max-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_KEY = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] key_out;
    logic [1:0]         status;
    logic [6:0]         occupancy;
  } out_item_t;

  // microprogram addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_DISP  = 4'd1;
  localparam step_t STEP_PUSH0 = 4'd2;
  localparam step_t STEP_PUSH1 = 4'd3;
  localparam step_t STEP_PUSH2 = 4'd4;
  localparam step_t STEP_POP0  = 4'd5;
  localparam step_t STEP_POP1  = 4'd6;
  localparam step_t STEP_POP2  = 4'd7;
  localparam step_t STEP_POP3  = 4'd8;
  localparam step_t STEP_WRF   = 4'd9;
  localparam step_t STEP_DONE  = 4'd10;
  localparam step_t STEP_FULL  = 4'd11;
  localparam step_t STEP_EMPTY = 4'd12;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NEVER    = 4'd0,
    COND_NO_IN    = 4'd1,
    COND_IS_POP   = 4'd2,
    COND_FULL     = 4'd3,
    COND_EMPTY    = 4'd4,
    COND_AT_ROOT  = 4'd5,
    COND_STOP_UP  = 4'd6,
    COND_NO_KID   = 4'd7,
    COND_STOP_DN  = 4'd8,
    COND_OUT_BUSY = 4'd9
  } cond_t;

  // datapath operations, carried out only when the jump is not taken
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_PUSH_INIT = 4'd2,
    OP_RD_PARENT = 4'd3,
    OP_MOVE_UP   = 4'd4,
    OP_POP_INIT  = 4'd5,
    OP_POP_LATCH = 4'd6,
    OP_RD_KIDS   = 4'd7,
    OP_MOVE_DN   = 4'd8,
    OP_WR_FINAL  = 4'd9,
    OP_SET_FULL  = 4'd10,
    OP_SET_EMPTY = 4'd11,
    OP_POST      = 4'd12
  } op_t;

  typedef struct packed {
    logic  in_rdy;
    cond_t cond;
    step_t jmp;
    step_t nxt;
    op_t   op;
  } ctrl_word_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic at_root;
    logic stop_up;
    logic no_kid;
    logic stop_dn;
  } dp_flags_t;

endpackage

[hdl/max_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// binary max-heap priority queue of signed 32-bit keys, microcoded sift engine
// ----------------------------------------------------------------------------
// A push inserts key_in and sifts it up; a pop returns the largest key, moves
// the last key to the root and sifts it down (larger child, left on a tie).
// A push into a heap holding HEAP_DEPTH-1 keys is dropped with status full; a
// pop of an empty heap returns 0x7FFFFFFF with status empty. Every item gives
// exactly one result item carrying the low 7 bits of the key count. One item
// is worked at a time, and the engine is busy from the accepting edge until
// the result register is loaded. The sift loop spends a heap memory read and
// then a compare and write-back on each tree level. A finished result waits
// in an output register, so the next item is taken while it is still
// unclaimed; the engine then holds at its last step for as long as the older
// result stays unclaimed. The heap memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // sequencer state
  step_t      step_r, step_nxt;
  ctrl_word_t word;
  dp_flags_t  flags;
  logic       taken;
  op_t        op_exec;

  // result side
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  logic signed [31:0] res_key;
  logic [1:0]         res_status;
  logic [6:0]         occupancy;
  logic               out_busy;

  mhpq_ucode_rom u_rom (
    .step (step_r),
    .word (word)
  );

  mhpq_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op_exec),
    .in_data    (in_data),
    .flags      (flags),
    .res_key    (res_key),
    .res_status (res_status),
    .occupancy  (occupancy)
  );

  // only the idle step takes an item
  assign in_ready = word.in_rdy;

  // result register still holds an item nobody took
  assign out_busy = out_valid_r && !out_ready;

  // jump condition select
  always_comb begin
    case (word.cond)
      COND_NEVER:    taken = 1'b0;
      COND_NO_IN:    taken = !in_valid;
      COND_IS_POP:   taken = flags.is_pop;
      COND_FULL:     taken = flags.full;
      COND_EMPTY:    taken = flags.empty;
      COND_AT_ROOT:  taken = flags.at_root;
      COND_STOP_UP:  taken = flags.stop_up;
      COND_NO_KID:   taken = flags.no_kid;
      COND_STOP_DN:  taken = flags.stop_dn;
      COND_OUT_BUSY: taken = out_busy;
      default:       taken = 1'b0;
    endcase
  end

  // a taken jump skips the step's operation
  assign op_exec  = taken ? OP_NONE : word.op;
  assign step_nxt = taken ? word.jmp : word.nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // output register: loading a new item wins over draining the old one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op_exec == OP_POST) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_exec == OP_POST) begin
      out_data_r.key_out   <= res_key;
      out_data_r.status    <= res_status;
      out_data_r.occupancy <= occupancy;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/mhpq_ucode_rom.sv]
// ----------------------------------------------------------------------------
// mhpq_ucode_rom
// control store: one control word per microprogram step
// ----------------------------------------------------------------------------
module mhpq_ucode_rom
  import mhpq_pkg::*;
(
  input  step_t      step,
  output ctrl_word_t word
);

  always_comb begin
    word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE, op: OP_NONE};
    case (step)
      STEP_IDLE: begin
        word = '{in_rdy: 1'b1, cond: COND_NO_IN, jmp: STEP_IDLE, nxt: STEP_DISP,
                 op: OP_LOAD};
      end
      STEP_DISP: begin
        word = '{in_rdy: 1'b0, cond: COND_IS_POP, jmp: STEP_POP0, nxt: STEP_PUSH0,
                 op: OP_NONE};
      end
      STEP_PUSH0: begin
        word = '{in_rdy: 1'b0, cond: COND_FULL, jmp: STEP_FULL, nxt: STEP_PUSH1,
                 op: OP_PUSH_INIT};
      end
      STEP_PUSH1: begin
        word = '{in_rdy: 1'b0, cond: COND_AT_ROOT, jmp: STEP_WRF, nxt: STEP_PUSH2,
                 op: OP_RD_PARENT};
      end
      STEP_PUSH2: begin
        word = '{in_rdy: 1'b0, cond: COND_STOP_UP, jmp: STEP_WRF, nxt: STEP_PUSH1,
                 op: OP_MOVE_UP};
      end
      STEP_POP0: begin
        word = '{in_rdy: 1'b0, cond: COND_EMPTY, jmp: STEP_EMPTY, nxt: STEP_POP1,
                 op: OP_POP_INIT};
      end
      STEP_POP1: begin
        word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_POP2,
                 op: OP_POP_LATCH};
      end
      STEP_POP2: begin
        word = '{in_rdy: 1'b0, cond: COND_NO_KID, jmp: STEP_WRF, nxt: STEP_POP3,
                 op: OP_RD_KIDS};
      end
      STEP_POP3: begin
        word = '{in_rdy: 1'b0, cond: COND_STOP_DN, jmp: STEP_WRF, nxt: STEP_POP2,
                 op: OP_MOVE_DN};
      end
      STEP_WRF: begin
        word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_DONE,
                 op: OP_WR_FINAL};
      end
      STEP_DONE: begin
        word = '{in_rdy: 1'b0, cond: COND_OUT_BUSY, jmp: STEP_DONE, nxt: STEP_IDLE,
                 op: OP_POST};
      end
      STEP_FULL: begin
        word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_DONE,
                 op: OP_SET_FULL};
      end
      STEP_EMPTY: begin
        word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_DONE,
                 op: OP_SET_EMPTY};
      end
      default: begin
        word = '{in_rdy: 1'b0, cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE,
                 op: OP_NONE};
      end
    endcase
  end

endmodule

[hdl/mhpq_datapath.sv]
// ----------------------------------------------------------------------------
// mhpq_datapath
// heap memory, count, walk pointers and compare logic driven by the microcode
// ----------------------------------------------------------------------------
module mhpq_datapath
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  op_t                op,
  input  in_item_t           in_data,
  output dp_flags_t          flags,
  output logic signed [31:0] res_key,
  output logic [1:0]         res_status,
  output logic [6:0]         occupancy
);

  localparam int AW = $clog2(HEAP_DEPTH);

  logic signed [31:0] mem [HEAP_DEPTH];

  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW:0]        kid_r, kid_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               cmd_r, cmd_nxt;
  logic signed [31:0] res_key_r, res_key_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic signed [31:0] rd_a_r, rd_b_r;

  logic               rd_en;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  logic               take_right;
  logic signed [31:0] big_key;
  logic [AW-1:0]      big_idx;
  logic [AW:0]        kid_inc;

  // larger child, left one on a tie
  assign kid_inc    = kid_r + (AW+1)'(1);
  assign take_right = (kid_r < {1'b0, cnt_r}) && (rd_a_r < rd_b_r);
  assign big_key    = take_right ? rd_b_r : rd_a_r;
  assign big_idx    = take_right ? kid_inc[AW-1:0] : kid_r[AW-1:0];

  assign flags.is_pop  = cmd_r;
  assign flags.full    = (cnt_r == AW'(HEAP_DEPTH - 1));
  assign flags.empty   = (cnt_r == '0);
  assign flags.at_root = (pos_r == AW'(1));
  assign flags.stop_up = !(key_r > rd_a_r);
  assign flags.no_kid  = (kid_r > {1'b0, cnt_r});
  assign flags.stop_dn = (key_r > big_key);

  assign res_key    = res_key_r;
  assign res_status = res_st_r;
  assign occupancy  = 7'(cnt_r);

  always_comb begin
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    kid_nxt     = kid_r;
    key_nxt     = key_r;
    cmd_nxt     = cmd_r;
    res_key_nxt = res_key_r;
    res_st_nxt  = res_st_r;
    rd_en       = 1'b0;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = key_r;
    case (op)
      OP_LOAD: begin
        cmd_nxt     = in_data.command;
        key_nxt     = in_data.key_in;
        res_key_nxt = '0;
        res_st_nxt  = STATUS_DONE;
      end
      OP_PUSH_INIT: begin
        cnt_nxt = cnt_r + AW'(1);
        pos_nxt = cnt_r + AW'(1);
      end
      OP_RD_PARENT: begin
        rd_en     = 1'b1;
        rd_addr_a = pos_r >> 1;
      end
      OP_MOVE_UP: begin
        wr_en   = 1'b1;
        wr_data = rd_a_r;
        pos_nxt = pos_r >> 1;
      end
      OP_POP_INIT: begin
        rd_en     = 1'b1;
        rd_addr_a = AW'(1);
        rd_addr_b = cnt_r;
        cnt_nxt   = cnt_r - AW'(1);
        pos_nxt   = AW'(1);
        kid_nxt   = (AW+1)'(2);
      end
      OP_POP_LATCH: begin
        res_key_nxt = rd_a_r;
        key_nxt     = rd_b_r;
      end
      OP_RD_KIDS: begin
        rd_en     = 1'b1;
        rd_addr_a = kid_r[AW-1:0];
        rd_addr_b = kid_inc[AW-1:0];
      end
      OP_MOVE_DN: begin
        wr_en   = 1'b1;
        wr_data = big_key;
        pos_nxt = big_idx;
        kid_nxt = {big_idx, 1'b0};
      end
      OP_WR_FINAL: begin
        wr_en = 1'b1;
      end
      OP_SET_FULL: begin
        res_st_nxt = STATUS_FULL;
      end
      OP_SET_EMPTY: begin
        res_st_nxt  = STATUS_EMPTY;
        res_key_nxt = EMPTY_KEY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    kid_r     <= kid_nxt;
    key_r     <= key_nxt;
    cmd_r     <= cmd_nxt;
    res_key_r <= res_key_nxt;
    res_st_r  <= res_st_nxt;
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

endmodule

[tb/max_heap_priority_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// self-checking bench for the max-heap priority queue
// ----------------------------------------------------------------------------
// A queue of push and pop items is played into the block through a driver,
// and a monitor compares every result with a software heap kept alongside.
// Three passes vary the idle rates of both sides. The stimulus is a mix of
// fill runs up to a full heap, drain runs past empty, and mixed stretches with
// many equal keys. One long receiver stall backs the block up into its input.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH  = 128;
  localparam int HEAP_LIMIT  = HEAP_DEPTH - 1;
  localparam int STALL_LEN   = 300;   // long receiver hold-off
  localparam int DRAIN_WAIT  = 50;    // well past the worst sift time
  localparam int WATCHDOG    = 4000;  // cycles with no item on either side
  localparam int RAND_ITEMS  = 460;   // random items per pass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // items waiting to be offered, and results owed by the block
  in_item_t  stim_queue[$];
  out_item_t result_due_q[$];

  // idle rates in percent, set per pass
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long stall request, taken up once by the monitor
  logic stall_armed = 1'b0;
  logic stall_done = 1'b0;
  int   stall_left = 0;

  // software heap: keys in slots 1..heap_count, root in slot 1
  logic signed [31:0] heap_slot [HEAP_DEPTH];
  int unsigned        heap_count = 0;

  // generator's own idea of the fill level, used to shape runs
  int unsigned stim_level = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int push_done = 0;
  int pop_done = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int peak_level = 0;
  int idle_cycles = 0;

  max_heap_priority_queue #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // apply one item to the software heap and return the result it owes
  function automatic out_item_t predict_heap_result(in_item_t item);
    out_item_t          res;
    logic signed [31:0] moved;
    logic signed [31:0] top;
    int unsigned        pos;
    int unsigned        kid;
    res = '0;
    if (item.command == CMD_PUSH) begin
      if (heap_count >= HEAP_LIMIT) begin
        res.status = STATUS_FULL;
      end else begin
        // climb while strictly above the parent
        heap_count++;
        pos = heap_count;
        moved = item.key_in;
        while (pos > 1 && moved > heap_slot[pos / 2]) begin
          heap_slot[pos] = heap_slot[pos / 2];
          pos = pos / 2;
        end
        heap_slot[pos] = moved;
        res.status = STATUS_DONE;
      end
      res.key_out = '0;
    end else begin
      if (heap_count == 0) begin
        res.key_out = EMPTY_KEY;
        res.status  = STATUS_EMPTY;
      end else begin
        top = heap_slot[1];
        moved = heap_slot[heap_count];
        heap_count--;
        pos = 1;
        kid = 2;
        // sink the last key: larger child, left one on a tie
        while (kid <= heap_count) begin
          if (kid < heap_count && heap_slot[kid] < heap_slot[kid + 1])
            kid++;
          if (moved > heap_slot[kid])
            break;
          heap_slot[pos] = heap_slot[kid];
          pos = kid;
          kid = kid * 2;
        end
        heap_slot[pos] = moved;
        res.key_out = top;
        res.status  = STATUS_DONE;
      end
    end
    res.occupancy = heap_count[6:0];
    return res;
  endfunction

  // keys: wide random, a narrow band for ties, and the ends of the range
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(9))
      5, 6, 7: k = int'($urandom_range(8)) - 4;
      8: begin
        case ($urandom_range(3))
          0: k = 32'sh8000_0000;
          1: k = 32'sh7FFF_FFFF;
          2: k = 32'sd0;
          default: k = -32'sd1;
        endcase
      end
      9: begin
        if ($urandom_range(1))
          k = 32'sh8000_0000 + int'($urandom_range(3));
        else
          k = 32'sh7FFF_FFFF - int'($urandom_range(3));
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic add_push(logic signed [31:0] k);
    in_item_t it;
    it.command = CMD_PUSH;
    it.key_in  = k;
    stim_queue.push_back(it);
    if (stim_level < HEAP_LIMIT)
      stim_level++;
  endtask

  // the key field of a pop is don't-care, so it carries noise
  task automatic add_pop();
    in_item_t it;
    it.command = CMD_POP;
    it.key_in  = $urandom;
    stim_queue.push_back(it);
    if (stim_level > 0)
      stim_level--;
  endtask

  // runs of fill, drain and mixed traffic until n items are queued
  task automatic add_random_items(int n);
    int made;
    int run_len;
    int push_pct;
    int extra;
    made = 0;
    while (made < n) begin
      case ($urandom_range(5))
        0: begin
          // fill to the top, then knock on a full heap
          extra = $urandom_range(1, 4);
          while (stim_level < HEAP_LIMIT) begin
            add_push(pick_key());
            made++;
          end
          repeat (extra) begin
            add_push(pick_key());
            made++;
          end
        end
        1: begin
          // drain to empty, then pop past the bottom
          extra = $urandom_range(1, 3);
          while (stim_level > 0) begin
            add_pop();
            made++;
          end
          repeat (extra) begin
            add_pop();
            made++;
          end
        end
        default: begin
          run_len = $urandom_range(20, 80);
          push_pct = 25 * $urandom_range(1, 3);
          repeat (run_len) begin
            if ($urandom_range(99) < push_pct)
              add_push(pick_key());
            else
              add_pop();
            made++;
          end
        end
      endcase
    end
  endtask

  // wait until every item is in and every result is back
  task automatic wait_drained();
    @(negedge clk);
    while (stim_queue.size() != 0 || in_valid || result_due_q.size() != 0)
      @(negedge clk);
  endtask

  // driver: offer items from the queue, predict on each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        result_due_q.push_back(predict_heap_result(in_data));
        items_sent++;
        if (in_data.command == CMD_PUSH)
          push_done++;
        else
          pop_done++;
      end
      if (stim_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= stim_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each accepted result against the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (result_due_q.size() == 0) begin
          $display("%0t: unexpected result key_out %0d status %0d occupancy %0d",
                   $time, out_data.key_out, out_data.status, out_data.occupancy);
          errors++;
        end else begin
          want = result_due_q.pop_front();
          if (out_data.key_out !== want.key_out) begin
            $display("%0t: key_out mismatch, expected %0d actual %0d",
                     $time, want.key_out, out_data.key_out);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_data.status);
            errors++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch, expected %0d actual %0d",
                     $time, want.occupancy, out_data.occupancy);
            errors++;
          end
          // tally what was covered
          if (want.status == STATUS_FULL)
            full_hits++;
          else if (want.status == STATUS_EMPTY)
            empty_hits++;
          if (int'(want.occupancy) > peak_level)
            peak_level = int'(want.occupancy);
        end
      end
      // one long hold-off while the sender keeps offering
      if (stall_armed && !stall_done) begin
        stall_left = STALL_LEN;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed",
               $time, WATCHDOG, result_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int tail_mark;

    // reset, held low from time zero and then released
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // first pass: sender idles a little, receiver a lot
    @(negedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 48;

    // directed: pop of an empty heap, range ends, ties, drain past empty
    add_pop();
    add_push(32'sd0);
    add_push(32'sh8000_0000);
    add_push(32'sh7FFF_FFFF);
    add_push(-32'sd1);
    add_push(32'sd5);
    add_push(32'sd5);
    add_push(32'sd5);
    add_push(32'sd3);
    add_push(32'sd7);
    repeat (10) add_pop();
    wait_drained();

    add_random_items(RAND_ITEMS);
    wait_drained();

    // second pass: the other way round
    send_idle_pct = 48;
    recv_idle_pct = 23;
    add_random_items(RAND_ITEMS);
    wait_drained();

    // third pass: no idling, with one long receiver stall part way in
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_items(RAND_ITEMS);
    tail_mark = stim_queue.size() - 100;
    while (stim_queue.size() > tail_mark)
      @(negedge clk);
    stall_armed = 1'b1;
    wait_drained();

    // let any stray result show up
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("run: %0d items in, %0d results out, heap peak %0d keys",
             items_sent, results_seen, peak_level);
    $display("run: %0d pushes (%0d dropped on full), %0d pops (%0d on empty)",
             push_done, full_hits, pop_done, empty_hits);
    if (errors == 0 && result_due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, result_due_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
